// ===== rtl/core/dmc_pkg.sv =====
`default_nettype none

package dmc_pkg;

    localparam int DEF_MAX_LINES  = 128;
    localparam int DEF_ADDR_WIDTH = 32;

    localparam int CNT_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 3;
    localparam int OFFSET_W    = 3;
    localparam int INDEX_W     = 3;
    localparam int RAW_LINE_W  = (1 << INDEX_W) - 1;
    localparam int RAW_LINES   = 1 << RAW_LINE_W;
    localparam int SHIFT_SUM_W = OFFSET_W + 1;

    localparam logic [OFFSET_W-1:0] OFFSET_BITS_RST = 3'd4;
    localparam logic [INDEX_W-1:0]  INDEX_BITS_RST  = 3'd6;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_BITS = 2'd0,
        CFG_INDEX_BITS  = 2'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_CLEAR  = 2'd0,
        ST_IDLE   = 2'd1,
        ST_LOOKUP = 2'd2
    } dmc_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/direct_mapped_cache_hit_miss.sv =====
// Direct-mapped cache tag store with hit/miss classification and counters.
//
// Request channel: req_valid/req_stall with one byte address per request.
// Response channel: rsp_valid/rsp_stall with hit, access_count and miss_count.
// Config channel: cfg_valid/cfg_ready (always ready); index 0 sets offset_bits,
// index 1 sets index_bits. Write config only while no request is in flight.
//
// A request takes two steps: a registered read of the line's {valid, tag} word
// from the single-port-read tag RAM, then a compare that writes back on a miss
// and loads the response register. The compare waits while the response
// register holds a stalled response, and no new request is accepted until the
// previous one has left the compare stage.
//
// After reset the block sweeps the tag RAM, one line per cycle, clearing every
// valid bit; req_stall stays high throughout the sweep. Counters reset to zero.
// A stalled response holds; one further request may be accepted meanwhile and
// waits in the compare stage until the response register frees.
`default_nettype none

module direct_mapped_cache_hit_miss #(
    parameter int MAX_LINES  = dmc_pkg::DEF_MAX_LINES,
    parameter int ADDR_WIDTH = dmc_pkg::DEF_ADDR_WIDTH
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            req_valid,
    output logic                                 req_stall,
    input  wire logic [ADDR_WIDTH-1:0]           address,
    output logic                                 rsp_valid,
    input  wire logic                            rsp_stall,
    output logic                                 hit,
    output logic      [dmc_pkg::CNT_W-1:0]       access_count,
    output logic      [dmc_pkg::CNT_W-1:0]       miss_count,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [dmc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [dmc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import dmc_pkg::*;

    localparam int LINE_W = $clog2(MAX_LINES);
    localparam int WORD_W = ADDR_WIDTH + 1;
    localparam logic [RAW_LINE_W-1:0] RAW_ONES = '1;
    localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(MAX_LINES - 1);

    dmc_state_t state_reg, state_next;

    logic [OFFSET_W-1:0]   offset_bits_reg;
    logic [INDEX_W-1:0]    index_bits_reg;
    logic [LINE_W-1:0]     clr_cnt_reg;
    logic [LINE_W-1:0]     line_reg;
    logic [ADDR_WIDTH-1:0] tag_reg;
    logic                  rsp_valid_reg;
    logic                  hit_reg;
    logic [CNT_W-1:0]      acc_reg, acc_next;
    logic [CNT_W-1:0]      miss_reg, miss_next;

    logic [ADDR_WIDTH-1:0] shifted;
    logic [RAW_LINE_W-1:0] idx_mask;
    logic [RAW_LINE_W-1:0] line_raw;
    logic [SHIFT_SUM_W-1:0] shift_sum;
    logic [ADDR_WIDTH-1:0] tag_now;
    logic [LINE_W-1:0]     line_map [RAW_LINES];

    logic                  req_accept;
    logic                  rsp_take;
    logic                  done;
    logic                  hit_now;
    logic                  wr_en;
    logic [LINE_W-1:0]     wr_addr;
    logic [WORD_W-1:0]     wr_data;
    logic [WORD_W-1:0]     rd_data;

    for (genvar g = 0; g < RAW_LINES; g++)
    begin : g_line_map
        assign line_map[g] = LINE_W'(g % MAX_LINES);
    end

    assign shifted   = address >> offset_bits_reg;
    assign idx_mask  = ~(RAW_ONES << index_bits_reg);
    assign line_raw  = shifted[RAW_LINE_W-1:0] & idx_mask;
    assign shift_sum = {1'b0, offset_bits_reg} + {1'b0, index_bits_reg};
    assign tag_now   = address >> shift_sum;

    assign req_accept = req_valid && !req_stall;
    assign rsp_take   = rsp_valid_reg && !rsp_stall;
    assign hit_now    = rd_data[ADDR_WIDTH] && (rd_data[ADDR_WIDTH-1:0] == tag_reg);
    assign done       = (state_reg == ST_LOOKUP) && (!rsp_valid_reg || !rsp_stall);

    assign acc_next  = (acc_reg == '1) ? acc_reg : acc_reg + 1'b1;
    assign miss_next = (miss_reg == '1) ? miss_reg : miss_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_stall  = 1'b1;
        wr_en      = 1'b0;
        wr_addr    = line_reg;
        wr_data    = {1'b1, tag_reg};
        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_cnt_reg;
                wr_data = '0;
                if (clr_cnt_reg == LAST_LINE)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (done)
                begin
                    wr_en      = !hit_now;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= OFFSET_BITS_RST;
            index_bits_reg  <= INDEX_BITS_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_OFFSET_BITS: offset_bits_reg <= cfg_data;
                CFG_INDEX_BITS:  index_bits_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            acc_reg       <= '0;
            miss_reg      <= '0;
        end
        else
        begin
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (done)
            begin
                rsp_valid_reg <= 1'b1;
                acc_reg       <= acc_next;
                if (!hit_now)
                begin
                    miss_reg <= miss_next;
                end
            end
            else if (rsp_take)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            line_reg <= line_map[line_raw];
            tag_reg  <= tag_now;
        end
        if (done)
        begin
            hit_reg <= hit_now;
        end
    end

    dmc_tag_ram #(
        .DEPTH (MAX_LINES),
        .WIDTH (WORD_W)
    ) u_tag_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (req_accept),
        .rd_addr (line_map[line_raw]),
        .rd_data (rd_data)
    );

    assign rsp_valid    = rsp_valid_reg;
    assign hit          = hit_reg;
    assign access_count = acc_reg;
    assign miss_count   = miss_reg;

    a_miss_le_access: assert property (@(posedge clk) disable iff (!rst_n)
        miss_reg <= acc_reg)
        else $error("miss count exceeds access count");

    a_done_gives_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> rsp_valid_reg)
        else $error("completed lookup did not present a response");

    a_hit_keeps_misses: assert property (@(posedge clk) disable iff (!rst_n)
        (done && hit_now) |=> $stable(miss_reg))
        else $error("miss count changed on a hit");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> req_stall)
        else $error("request accepted while lookup or clear in progress");

endmodule

`default_nettype wire

// ===== rtl/core/dmc_tag_ram.sv =====
`default_nettype none

module dmc_tag_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 33
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== test/direct_mapped_cache_hit_miss_test.sv =====
`timescale 1ns / 1ps

module direct_mapped_cache_hit_miss_test;

    import dmc_pkg::*;

    localparam int LINES       = 128;
    localparam int CYCLE_LIMIT = 300000;

    typedef struct packed {
        logic        hit;
        logic [31:0] accesses;
        logic [31:0] misses;
    } lookup_t;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        req_valid    = 1'b0;
    logic        req_stall;
    logic [31:0] address      = '0;
    logic        rsp_valid;
    logic        rsp_stall    = 1'b0;
    logic        hit;
    logic [31:0] access_count;
    logic [31:0] miss_count;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    cfg_reg_t    cfg_index    = CFG_OFFSET_BITS;
    logic [2:0]  cfg_data     = '0;

    logic        line_valid [LINES];
    logic [31:0] line_tag [LINES];
    logic [31:0] total_accesses;
    logic [31:0] total_misses;
    logic [2:0]  split_offset;
    logic [2:0]  split_index;

    lookup_t     expected_lookups [$];
    logic [31:0] recent_addresses [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_cycles    = 0;
    int cycle_count    = 0;
    int error_count    = 0;
    int requests_sent  = 0;
    int hits_seen      = 0;
    int splits_used    = 0;

    direct_mapped_cache_hit_miss DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .address      (address),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .hit          (hit),
        .access_count (access_count),
        .miss_count   (miss_count),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            rsp_stall   <= 1'b1;
        end
        else
        begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_responses
        lookup_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_lookups.size() == 0)
            begin
                $error("response with no request outstanding");
                error_count++;
            end
            else
            begin
                want = expected_lookups.pop_front();
                if (hit !== want.hit)
                begin
                    $error("hit: expected %0d, actual %0d", want.hit, hit);
                    error_count++;
                end
                if (access_count !== want.accesses)
                begin
                    $error("access_count: expected %0d, actual %0d",
                           want.accesses, access_count);
                    error_count++;
                end
                if (miss_count !== want.misses)
                begin
                    $error("miss_count: expected %0d, actual %0d",
                           want.misses, miss_count);
                    error_count++;
                end
                if (hit === 1'b1)
                    hits_seen++;
            end
        end
    end

    function automatic lookup_t predict_lookup(input logic [31:0] addr);
        lookup_t     result;
        logic [31:0] line_sel;
        logic [6:0]  line;
        logic [31:0] tag;
        line_sel = (addr >> split_offset) & ((32'd1 << split_index) - 32'd1);
        line     = line_sel[6:0];
        tag      = addr >> ({1'b0, split_offset} + {1'b0, split_index});
        if (total_accesses != '1)
            total_accesses++;
        result.hit = line_valid[line] && (line_tag[line] == tag);
        if (!result.hit)
        begin
            line_valid[line] = 1'b1;
            line_tag[line]   = tag;
            if (total_misses != '1)
                total_misses++;
        end
        result.accesses = total_accesses;
        result.misses   = total_misses;
        return result;
    endfunction

    function automatic logic [31:0] pick_address();
        int          r;
        logic [31:0] a;
        r = $urandom_range(99);
        if (r < 50 && recent_addresses.size() > 0)
        begin
            a = recent_addresses[$urandom_range(recent_addresses.size() - 1)];
            a = a ^ ($urandom & ((32'd1 << split_offset) - 32'd1));
        end
        else if (r < 80)
            a = (32'($urandom_range(3)) << 20) | ($urandom & 32'h0000_3FFF);
        else
            a = $urandom;
        recent_addresses.push_back(a);
        if (recent_addresses.size() > 16)
            void'(recent_addresses.pop_front());
        return a;
    endfunction

    task automatic send_access(input logic [31:0] addr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        address   <= addr;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        expected_lookups.push_back(predict_lookup(addr));
        requests_sent++;
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (expected_lookups.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_split_reg(input cfg_reg_t idx, input logic [2:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_OFFSET_BITS)
            split_offset = value;
        else
            split_index = value;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_split(input logic [2:0] ob, input logic [2:0] ib);
        wait_drained();
        write_split_reg(CFG_OFFSET_BITS, ob);
        write_split_reg(CFG_INDEX_BITS, ib);
        splits_used++;
    endtask

    task automatic test_default_split();
        send_idle_pct  = 10;
        recv_stall_pct = 10;
        send_access(32'h0000_0000);
        send_access(32'h0000_0000);
        send_access(32'hFFFF_FFFF);
        send_access(32'hFFFF_FFFF);
        send_access(32'h0000_000F);
        send_access(32'h0001_0000);
        send_access(32'h0000_0000);
        send_access(32'h0000_0010);
        wait_drained();
    endtask

    task automatic test_split_extremes();
        set_split(3'd0, 3'd0);
        send_access(32'hA5A5_A5A5);
        send_access(32'hA5A5_A5A5);
        send_access(32'h5A5A_5A5A);
        send_access(32'hA5A5_A5A5);
        set_split(3'd7, 3'd7);
        send_access(32'hFFFF_FFFF);
        send_access(32'hFFFF_C07F);
        send_access(32'h0000_3F80);
        send_access(32'h0000_0000);
        send_access(32'hFFFF_FFFF);
        set_split(3'd2, 3'd3);
        send_access(32'h0000_0000);
        send_access(32'hFFFF_FFFF);
        send_access(32'hFFFF_FFE0);
        wait_drained();
    endtask

    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_split(3'd4, 3'd6);
        hold_cycles = 80;
        repeat (30) send_access(pick_address());
        wait_drained();
    endtask

    task automatic run_traffic(input int items, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int chunk = 0; chunk < 3; chunk++)
        begin
            set_split(3'($urandom_range(7)), 3'($urandom_range(7)));
            recent_addresses.delete();
            repeat (items / 3) send_access(pick_address());
        end
        wait_drained();
    endtask

    initial
    begin
        for (int i = 0; i < LINES; i++)
        begin
            line_valid[i] = 1'b0;
            line_tag[i]   = '0;
        end
        total_accesses = '0;
        total_misses   = '0;
        split_offset   = OFFSET_BITS_RST;
        split_index    = INDEX_BITS_RST;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_split();
        test_split_extremes();
        test_backpressure();
        run_traffic(270, 18, 63);
        run_traffic(270, 63, 18);
        run_traffic(270, 0, 0);

        wait_drained();
        repeat (10) @(posedge clk);
        $display("covered %0d lookups (%0d hits) across %0d offset/index splits",
                 requests_sent, hits_seen, splits_used);
        $display("with sender gaps, response stalls and a long response hold-off");
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/dmc_pkg.sv
rtl/core/dmc_tag_ram.sv
rtl/core/direct_mapped_cache_hit_miss.sv
test/direct_mapped_cache_hit_miss_test.sv
